FILE: hdl/assert_macros.svh
// Assertion macros used by mer_checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

FILE: hdl/mer_pkg.sv
// Shared types and codes of the midpoint ellipse rasterizer.
// Used by mer_ctrl, mer_datapath, the top level and mer_checker; no dependencies.
`timescale 1ns / 1ps

package mer_pkg;

	localparam int INK_BITS = 8;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_NEXT  = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INIT0,
		ST_INIT1,
		ST_INIT2,
		ST_INIT3,
		ST_STEP1,
		ST_STEP2,
		ST_UPD,
		ST_R2_0,
		ST_R2_1,
		ST_R2_2,
		ST_R2_3,
		ST_R2_4,
		ST_R2_5,
		ST_R2_6,
		ST_R2_7,
		ST_FIN,
		ST_EMIT
	} mer_state_t;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_AA,
		MUL_BB,
		MUL_A2B,
		MUL_BX,
		MUL_PP,
		MUL_BT,
		MUL_AY,
		MUL_AB
	} mul_sel_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD_START,
		OP_SAVE_A2,
		OP_SAVE_B2,
		OP_SEED,
		OP_STEP_R1,
		OP_STEP_R2,
		OP_ACC_UPD,
		OP_SAVE_T,
		OP_ACC_LOAD,
		OP_ACC_ADD,
		OP_ENTER_R2,
		OP_STOP
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       mul_en;
		mul_sel_t   mul_sel;
		logic       out_load;
		logic       out_fin;
		logic [1:0] out_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic drawing;
		logic region2;
		logic y_zero;
		logic gx_lt_gy;
		logic out_last;
	} dp_stat_t;

endpackage

FILE: hdl/mer_datapath.sv
// Datapath: ellipse state, shared multiplier, decision accumulator, result register.
// Depends on mer_pkg; driven by mer_ctrl commands.
`timescale 1ns / 1ps

module mer_datapath import mer_pkg::*; #(
	parameter int AXIS_BITS  = 10,
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [AXIS_BITS-1:0]         semi_axis_x,
	input  logic [AXIS_BITS-1:0]         semi_axis_y,
	input  logic [INK_BITS-1:0]          ink,
	output dp_stat_t                     stat,
	output logic signed [COORD_BITS:0]   pixel_x,
	output logic signed [COORD_BITS:0]   pixel_y,
	output logic [INK_BITS-1:0]          pixel_ink,
	output logic                         pixel_valid,
	output logic                         step_last,
	output logic                         finished
);

	localparam int AW  = AXIS_BITS;
	localparam int MW  = 2 * AW;
	localparam int PRW = 4 * AW;
	localparam int GW  = 3 * AW + 2;
	localparam int KW  = 2 * AW + 4;
	localparam int KTW = 3 * AW + 3;
	localparam int DW  = 4 * AW + 6;
	localparam int PW  = COORD_BITS + 1;

	logic [AW-1:0]                a_q, b_q, x_q, y_q;
	logic [MW-1:0]                a2_q, b2_q, t_q;
	logic [PRW-1:0]               prod_q;
	logic [GW-1:0]                gx_q, gy_q, gyterm_q;
	logic [KW-1:0]                k1_q, k2_q, k3_q, k4_q;
	logic [KTW-1:0]               kterm_q;
	logic signed [DW-1:0]         d_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic [INK_BITS-1:0]          ink_q;
	logic                         drawing_q, region2_q;

	logic signed [PW-1:0] out_x_q, out_y_q;
	logic [INK_BITS-1:0]  out_ink_q;
	logic                 out_pv_q, out_last_q, out_fin_q;

	logic [MW-1:0] mul_a, mul_b;
	logic [AW-1:0] ty;
	logic [GW-1:0] gx_step, gy_step;
	logic [MW:0]   rnd_a, rnd_b;
	logic [KW-1:0] k1_new, k3_new;
	logic          d_neg;
	logic signed [PW-1:0] cx_ext, cy_ext, x_ext, y_ext;

	assign ty      = (y_q == '0) ? AW'(1) : y_q - AW'(1);
	assign gx_step = gx_q + GW'({b2_q, 1'b0});
	assign gy_step = gy_q - GW'({a2_q, 1'b0});
	assign rnd_a   = ({1'b0, a2_q} + (MW+1)'(2)) >> 2;
	assign rnd_b   = ({1'b0, b2_q} + (MW+1)'(2)) >> 2;
	assign k1_new  = KW'({b2_q, 2'b00}) + KW'(b2_q);
	assign k3_new  = KW'({a2_q, 2'b00}) + KW'(a2_q);
	assign d_neg   = d_q[DW-1];

	assign cx_ext = PW'(cx_q);
	assign cy_ext = PW'(cy_q);
	assign x_ext  = PW'(x_q);
	assign y_ext  = PW'(y_q);

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_AA:  begin mul_a = MW'(a_q);           mul_b = MW'(a_q); end
			MUL_BB:  begin mul_a = MW'(b_q);           mul_b = MW'(b_q); end
			MUL_A2B: begin mul_a = a2_q;               mul_b = MW'(b_q); end
			MUL_BX:  begin mul_a = MW'(b_q);           mul_b = MW'(x_q); end
			MUL_PP:  begin mul_a = prod_q[MW-1:0];     mul_b = prod_q[MW-1:0]; end
			MUL_BT:  begin mul_a = MW'(b_q);           mul_b = t_q; end
			MUL_AY:  begin mul_a = MW'(a_q);           mul_b = MW'(ty); end
			MUL_AB:  begin mul_a = MW'(a_q);           mul_b = MW'(b_q); end
			default: begin mul_a = '0;                 mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drawing_q <= 1'b0;
			region2_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_LOAD_START: begin
					drawing_q <= 1'b1;
					region2_q <= 1'b0;
				end
				OP_ENTER_R2: region2_q <= 1'b1;
				OP_STOP:     drawing_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= PRW'(mul_a) * PRW'(mul_b);

		unique case (cmd.op)
			OP_LOAD_START: begin
				a_q   <= semi_axis_x;
				b_q   <= semi_axis_y;
				cx_q  <= center_x;
				cy_q  <= center_y;
				ink_q <= ink;
				x_q   <= '0;
				y_q   <= semi_axis_y;
				gx_q  <= '0;
			end
			OP_SAVE_A2: a2_q <= prod_q[MW-1:0];
			OP_SAVE_B2: b2_q <= prod_q[MW-1:0];
			OP_SEED: begin
				gy_q <= {prod_q[GW-2:0], 1'b0};
				d_q  <= DW'(b2_q) - DW'(prod_q) + DW'(rnd_a);
				k1_q <= k1_new;
				k2_q <= k1_new + KW'({a2_q, 2'b00});
				k3_q <= k3_new;
				k4_q <= k3_new + KW'({b2_q, 2'b00});
			end
			OP_STEP_R1: begin
				x_q  <= x_q + AW'(1);
				gx_q <= gx_step;
				if (d_neg) begin
					kterm_q  <= KTW'(gx_q) + KTW'(k1_q);
					gyterm_q <= '0;
				end else begin
					y_q      <= y_q - AW'(1);
					gy_q     <= gy_step;
					kterm_q  <= KTW'(gx_q) + KTW'(k2_q);
					gyterm_q <= gy_q;
				end
			end
			OP_STEP_R2: begin
				y_q      <= y_q - AW'(1);
				gy_q     <= gy_step;
				gyterm_q <= gy_q;
				if (!d_neg) begin
					kterm_q <= KTW'(k3_q);
				end else begin
					x_q     <= x_q + AW'(1);
					gx_q    <= gx_step;
					kterm_q <= KTW'(gx_q) + KTW'(k4_q);
				end
			end
			OP_ACC_UPD:  d_q <= d_q + DW'(kterm_q) - DW'(gyterm_q);
			OP_SAVE_T:   t_q <= prod_q[MW-1:0];
			OP_ACC_LOAD: d_q <= DW'(prod_q) + DW'(rnd_b);
			OP_ACC_ADD:  d_q <= d_q + DW'(prod_q);
			OP_ENTER_R2: d_q <= d_q - DW'(prod_q);
			default: ;
		endcase

		if (cmd.out_load) begin
			if (cmd.out_fin) begin
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_ink_q  <= '0;
				out_pv_q   <= 1'b0;
				out_last_q <= 1'b1;
				out_fin_q  <= 1'b1;
			end else begin
				out_x_q    <= cmd.out_idx[0] ? cx_ext - x_ext : cx_ext + x_ext;
				out_y_q    <= cmd.out_idx[1] ? cy_ext - y_ext : cy_ext + y_ext;
				out_ink_q  <= ink_q;
				out_pv_q   <= 1'b1;
				out_last_q <= (cmd.out_idx == 2'd3);
				out_fin_q  <= 1'b0;
			end
		end
	end

	assign stat.drawing  = drawing_q;
	assign stat.region2  = region2_q;
	assign stat.y_zero   = (y_q == '0);
	assign stat.gx_lt_gy = (gx_q < gy_q);
	assign stat.out_last = out_last_q;

	assign pixel_x     = out_x_q;
	assign pixel_y     = out_y_q;
	assign pixel_ink   = out_ink_q;
	assign pixel_valid = out_pv_q;
	assign step_last   = out_last_q;
	assign finished    = out_fin_q;

endmodule

FILE: hdl/mer_ctrl.sv
// Controller state machine: sequences start seeding, steps, region switch and result output.
// Depends on mer_pkg; commands mer_datapath.
`timescale 1ns / 1ps

module mer_ctrl import mer_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_type,
	input  logic     res_stall,
	input  dp_stat_t stat,
	output logic     req_stall,
	output logic     res_valid,
	output dp_cmd_t  cmd
);

	mer_state_t state_q, state_nx;
	logic [1:0] idx_q;
	logic       req_fire;

	assign req_fire  = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = (state_q == ST_EMIT);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req_type == REQ_START)
						state_nx = ST_INIT0;
					else if (!stat.drawing)
						state_nx = ST_FIN;
					else if (stat.region2)
						state_nx = stat.y_zero ? ST_FIN : ST_STEP2;
					else
						state_nx = stat.gx_lt_gy ? ST_STEP1 : ST_R2_0;
				end
			end
			ST_INIT0: state_nx = ST_INIT1;
			ST_INIT1: state_nx = ST_INIT2;
			ST_INIT2: state_nx = ST_INIT3;
			ST_INIT3: state_nx = ST_EMIT;
			ST_STEP1: state_nx = ST_UPD;
			ST_STEP2: state_nx = ST_UPD;
			ST_UPD:   state_nx = ST_EMIT;
			ST_R2_0:  state_nx = ST_R2_1;
			ST_R2_1:  state_nx = ST_R2_2;
			ST_R2_2:  state_nx = ST_R2_3;
			ST_R2_3:  state_nx = ST_R2_4;
			ST_R2_4:  state_nx = ST_R2_5;
			ST_R2_5:  state_nx = ST_R2_6;
			ST_R2_6:  state_nx = ST_R2_7;
			ST_R2_7:  state_nx = stat.y_zero ? ST_FIN : ST_STEP2;
			ST_FIN:   state_nx = ST_EMIT;
			ST_EMIT: begin
				if (!res_stall && stat.out_last)
					state_nx = ST_IDLE;
			end
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.op       = OP_NONE;
		cmd.mul_sel  = MUL_AA;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire && req_type == REQ_START)
					cmd.op = OP_LOAD_START;
			end
			ST_INIT0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AA;
			end
			ST_INIT1: begin
				cmd.op      = OP_SAVE_A2;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_BB;
			end
			ST_INIT2: begin
				cmd.op      = OP_SAVE_B2;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_A2B;
			end
			ST_INIT3: begin
				cmd.op       = OP_SEED;
				cmd.out_load = 1'b1;
			end
			ST_STEP1: cmd.op = OP_STEP_R1;
			ST_STEP2: cmd.op = OP_STEP_R2;
			ST_UPD: begin
				cmd.op       = OP_ACC_UPD;
				cmd.out_load = 1'b1;
			end
			ST_R2_0: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_BX;
			end
			ST_R2_1: begin
				cmd.op      = OP_SAVE_T;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PP;
			end
			ST_R2_2: begin
				cmd.op      = OP_ACC_LOAD;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_BT;
			end
			ST_R2_3: begin
				cmd.op      = OP_ACC_ADD;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AY;
			end
			ST_R2_4: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PP;
			end
			ST_R2_5: begin
				cmd.op      = OP_ACC_ADD;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AB;
			end
			ST_R2_6: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PP;
			end
			ST_R2_7: cmd.op = OP_ENTER_R2;
			ST_FIN: begin
				cmd.op       = OP_STOP;
				cmd.out_load = 1'b1;
				cmd.out_fin  = 1'b1;
			end
			ST_EMIT: begin
				if (!res_stall && !stat.out_last) begin
					cmd.out_load = 1'b1;
					cmd.out_idx  = idx_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				idx_q <= cmd.out_idx;
		end
	end

endmodule

FILE: hdl/midpoint_ellipse_rasterizer_unit.sv
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
// Depends on mer_pkg, mer_ctrl and mer_datapath.
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_valid / req_stall): req_type 0 starts an ellipse from
//   center_x, center_y, semi_axis_x, semi_axis_y and ink; req_type 1 asks for
//   the next point. A request is taken only while req_stall is low, which is
//   the case only when the block is idle.
//   Result channel (res_valid / res_stall): each point gives four pixels in the
//   order (+x,+y), (-x,+y), (+x,-y), (-x,-y), one per cycle while res_stall is
//   low; step_last marks the fourth. A next request after the last point gives
//   one finished marker. A start runs the seeding states INIT0 to INIT3 before
//   its first result; a normal step runs the step/update pair and then the four
//   results of the single output register; a region switch first runs states
//   R2_0 to R2_7 with the shared multiplier; a finished marker runs state FIN.
//   res_stall holds the current result and the sequencer; nothing is dropped.
//   Reset leaves the block idle with no ellipse loaded; a next request then
//   gives the finished marker.
module midpoint_ellipse_rasterizer_unit import mer_pkg::*; #(
	parameter int AXIS_BITS  = 10,
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         req_type,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [AXIS_BITS-1:0]         semi_axis_x,
	input  logic [AXIS_BITS-1:0]         semi_axis_y,
	input  logic [INK_BITS-1:0]          ink,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic signed [COORD_BITS:0]   pixel_x,
	output logic signed [COORD_BITS:0]   pixel_y,
	output logic [INK_BITS-1:0]          pixel_ink,
	output logic                         pixel_valid,
	output logic                         step_last,
	output logic                         finished
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.res_stall (res_stall),
		.stat      (stat),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.cmd       (cmd)
	);

	mer_datapath #(
		.AXIS_BITS  (AXIS_BITS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.center_x    (center_x),
		.center_y    (center_y),
		.semi_axis_x (semi_axis_x),
		.semi_axis_y (semi_axis_y),
		.ink         (ink),
		.stat        (stat),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_ink   (pixel_ink),
		.pixel_valid (pixel_valid),
		.step_last   (step_last),
		.finished    (finished)
	);

endmodule

FILE: hdl/mer_checker.sv
// Port-level checks of the ellipse rasterizer, bound to the top level.
// Depends on mer_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mer_checker import mer_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_stall,
	input logic                         res_valid,
	input logic                         res_stall,
	input logic signed [COORD_BITS:0]   pixel_x,
	input logic signed [COORD_BITS:0]   pixel_y,
	input logic [INK_BITS-1:0]          pixel_ink,
	input logic                         pixel_valid,
	input logic                         step_last,
	input logic                         finished
);

	// one request in flight: no request taken while results are pending
	`ASSERT_IMPLY(a_busy_while_out, clk, arst_n, res_valid, req_stall)

	// a result is either a pixel or the finished marker
	`ASSERT_IMPLY(a_kind, clk, arst_n, res_valid, pixel_valid != finished)

	// finished marker is a single, blank, last result
	`ASSERT_IMPLY(a_fin_blank, clk, arst_n, res_valid && finished,
		step_last && pixel_x == '0 && pixel_y == '0 && pixel_ink == '0)

	// stalled result holds
	`ASSERT_NEXT(a_hold, clk, arst_n, res_valid && res_stall,
		res_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(step_last))

endmodule

bind midpoint_ellipse_rasterizer_unit mer_checker #(
	.COORD_BITS (COORD_BITS)
) u_mer_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_stall   (req_stall),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.pixel_ink   (pixel_ink),
	.pixel_valid (pixel_valid),
	.step_last   (step_last),
	.finished    (finished)
);
